// File: hdl/fls_pkg.sv
// Shared constants and control types for the fixed-point line stepper.
package fls_pkg;

    localparam int COORD_BITS_DEF  = 12;
    localparam int FRAC_BITS_DEF   = 10;
    localparam int ROW_W           = 13;
    localparam int ADDR_W          = 24;
    localparam int COLOUR_W        = 8;
    localparam int ROW_WIDTH_RESET = 320;
    // Command queue depth, must be a power of two.
    localparam int QUEUE_DEPTH     = 4;

    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    typedef struct packed {
        logic is_start;
        logic major_x;
        logic major_neg;
        logic minor_neg;
    } fls_cmd_t;

endpackage

// File: hdl/fls_ifs.sv
// Valid/ready channel interfaces for line commands and pixel results.
interface fls_item_if
    import fls_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic                  kind;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
    logic [COLOUR_W-1:0]   colour;

    modport source (output valid, kind, start_x, start_y, end_x, end_y, colour,
                    input ready);
    modport sink   (input valid, kind, start_x, start_y, end_x, end_y, colour,
                    output ready);
endinterface

interface fls_pixel_if
    import fls_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [ADDR_W-1:0]     pixel_address;
    logic [COLOUR_W-1:0]   pixel_colour;
    logic                  last_pixel;

    modport source (output valid, pixel_x, pixel_y, pixel_address, pixel_colour,
                    last_pixel, input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_address, pixel_colour,
                    last_pixel, output ready);
endinterface

// File: hdl/fls_front.sv
// Front end: accepts commands, works out line setup, queues them for the back end.
module fls_front
    import fls_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    fls_item_if.sink              item,
    output logic                  head_valid,
    output fls_cmd_t              head_cmd,
    output logic [COORD_BITS-1:0] head_x0,
    output logic [COORD_BITS-1:0] head_y0,
    output logic [COORD_BITS:0]   head_len,
    output logic [COORD_BITS:0]   head_adj,
    output logic [COLOUR_W-1:0]   head_colour,
    input  logic                  pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    fls_cmd_t              cmd_q    [QUEUE_DEPTH];
    logic [COORD_BITS-1:0] x0_q     [QUEUE_DEPTH];
    logic [COORD_BITS-1:0] y0_q     [QUEUE_DEPTH];
    logic [COORD_BITS:0]   len_q    [QUEUE_DEPTH];
    logic [COORD_BITS:0]   adj_q    [QUEUE_DEPTH];
    logic [COLOUR_W-1:0]   colour_q [QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic                  push;
    logic                  x_fwd, y_fwd;
    logic [COORD_BITS-1:0] adx, ady;
    fls_cmd_t              new_cmd;
    logic [COORD_BITS:0]   new_len, new_adj;

    // setup classification
    always_comb
    begin
        x_fwd = item.end_x >= item.start_x;
        y_fwd = item.end_y >= item.start_y;
        adx   = x_fwd ? item.end_x - item.start_x : item.start_x - item.end_x;
        ady   = y_fwd ? item.end_y - item.start_y : item.start_y - item.end_y;
        new_cmd.is_start  = (item.kind == KIND_START);
        new_cmd.major_x   = (adx >= ady);
        new_cmd.major_neg = new_cmd.major_x ? !x_fwd : !y_fwd;
        new_cmd.minor_neg = new_cmd.major_x ? !y_fwd : !x_fwd;
        // len = major delta + 1; minor magnitude |d| + 1, sign from direction
        new_len = {1'b0, (new_cmd.major_x ? adx : ady)} + (COORD_BITS+1)'(1);
        new_adj = {1'b0, (new_cmd.major_x ? ady : adx)} + (COORD_BITS+1)'(1);
    end

    always_comb
    begin
        item.ready  = (count_reg != CNT_W'(QUEUE_DEPTH));
        push        = item.valid && item.ready;
        head_valid  = (count_reg != '0);
        wr_ptr_next = push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
        head_cmd    = cmd_q[rd_ptr_reg];
        head_x0     = x0_q[rd_ptr_reg];
        head_y0     = y0_q[rd_ptr_reg];
        head_len    = len_q[rd_ptr_reg];
        head_adj    = adj_q[rd_ptr_reg];
        head_colour = colour_q[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            cmd_q[wr_ptr_reg]    <= new_cmd;
            x0_q[wr_ptr_reg]     <= item.start_x;
            y0_q[wr_ptr_reg]     <= item.start_y;
            len_q[wr_ptr_reg]    <= new_len;
            adj_q[wr_ptr_reg]    <= new_adj;
            colour_q[wr_ptr_reg] <= item.colour;
        end
    end

endmodule

// File: hdl/fls_div.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
module fls_div
    import fls_pkg::*;
#(
    parameter int NUM_W = COORD_BITS_DEF + 1 + FRAC_BITS_DEF,
    parameter int DEN_W = COORD_BITS_DEF + 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   trial;
    logic             fits;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[NUM_W-1]};
        fits      = (trial >= {1'b0, den_reg});
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            quo_next  = num;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
        busy = busy_reg;
        quo  = quo_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

endmodule

// File: hdl/fls_back.sv
// Back end: line state, accumulator stepping, address multiply and output register.
module fls_back
    import fls_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  fls_cmd_t              head_cmd,
    input  logic [COORD_BITS-1:0] head_x0,
    input  logic [COORD_BITS-1:0] head_y0,
    input  logic [COORD_BITS:0]   head_len,
    input  logic [COLOUR_W-1:0]   head_colour,
    output logic                  pop,
    output logic                  div_start,
    input  logic                  div_busy,
    input  logic [FRAC_BITS:0]    div_quo,
    input  logic [ROW_W-1:0]      row_width,
    fls_pixel_if.source           pixel
);

    localparam int ACC_W = COORD_BITS + FRAC_BITS + 2;
    localparam int PIX_W = COORD_BITS + 2;
    localparam logic [ACC_W-1:0] ONE_PIXEL =
        {{(ACC_W-1-FRAC_BITS){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

    typedef enum logic {ST_IDLE, ST_DIV} state_t;

    state_t                state_reg, state_next;
    logic [ACC_W-1:0]      x_acc_reg, x_acc_next;
    logic [ACC_W-1:0]      y_acc_reg, y_acc_next;
    logic [ACC_W-1:0]      x_step_reg, x_step_next;
    logic [ACC_W-1:0]      y_step_reg, y_step_next;
    logic [COORD_BITS-1:0] left_reg, left_next;
    logic [COLOUR_W-1:0]   colour_reg, colour_next;

    logic                  p1_valid_reg, p1_valid_next;
    logic signed [PIX_W-1:0] p1_x_reg, p1_y_reg;
    logic                  p1_last_reg;
    logic [COLOUR_W-1:0]   p1_colour_reg;

    logic                  out_valid_reg, out_valid_next;
    logic [COORD_BITS-1:0] out_x_reg, out_y_reg;
    logic [ADDR_W-1:0]     out_addr_reg;
    logic [COLOUR_W-1:0]   out_colour_reg;
    logic                  out_last_reg;

    logic                  out_load, p1_free, p1_load;
    logic                  adv_go, adv_emit, start_go;
    logic [ACC_W-1:0]      major_step, minor_step;
    logic [COORD_BITS:0]   len_m1;
    logic [ADDR_W-1:0]     y_ext, x_ext;
    logic [ADDR_W+ROW_W-1:0] row_prod;
    logic [ADDR_W-1:0]     addr_calc;

    always_comb
    begin
        out_load = p1_valid_reg && (!out_valid_reg || pixel.ready);
        p1_free  = !p1_valid_reg || out_load;
        // advance with no line active is dropped without a result
        adv_go    = (state_reg == ST_IDLE) && head_valid && !head_cmd.is_start &&
                    ((left_reg == '0) || p1_free);
        adv_emit  = adv_go && (left_reg != '0);
        div_start = (state_reg == ST_IDLE) && head_valid && head_cmd.is_start;
        start_go  = (state_reg == ST_DIV) && !div_busy && p1_free;
        pop       = adv_go || start_go;
        p1_load   = start_go || adv_emit;

        major_step = head_cmd.major_neg ? ACC_W'(-ONE_PIXEL) : ONE_PIXEL;
        minor_step = head_cmd.minor_neg ? ACC_W'(-ACC_W'(div_quo)) : ACC_W'(div_quo);
        len_m1     = head_len - (COORD_BITS+1)'(1);

        state_next  = state_reg;
        x_acc_next  = x_acc_reg;
        y_acc_next  = y_acc_reg;
        x_step_next = x_step_reg;
        y_step_next = y_step_reg;
        left_next   = left_reg;
        colour_next = colour_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (div_start)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (start_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (start_go)
        begin
            x_acc_next  = {2'b00, head_x0, {FRAC_BITS{1'b0}}};
            y_acc_next  = {2'b00, head_y0, {FRAC_BITS{1'b0}}};
            x_step_next = head_cmd.major_x ? major_step : minor_step;
            y_step_next = head_cmd.major_x ? minor_step : major_step;
            left_next   = len_m1[COORD_BITS-1:0];
            colour_next = head_colour;
        end
        else if (adv_emit)
        begin
            x_acc_next = x_acc_reg + x_step_reg;
            y_acc_next = y_acc_reg + y_step_reg;
            left_next  = left_reg - 1'b1;
        end

        p1_valid_next  = p1_load || (p1_valid_reg && !out_load);
        out_valid_next = out_load || (out_valid_reg && !pixel.ready);

        // address from floored signed coordinates, modulo 2^ADDR_W
        y_ext     = ADDR_W'(p1_y_reg);
        x_ext     = ADDR_W'(p1_x_reg);
        row_prod  = y_ext * {{ADDR_W{1'b0}}, row_width};
        addr_calc = row_prod[ADDR_W-1:0] + x_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            x_acc_reg     <= '0;
            y_acc_reg     <= '0;
            x_step_reg    <= '0;
            y_step_reg    <= '0;
            left_reg      <= '0;
            colour_reg    <= '0;
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            x_acc_reg     <= x_acc_next;
            y_acc_reg     <= y_acc_next;
            x_step_reg    <= x_step_next;
            y_step_reg    <= y_step_next;
            left_reg      <= left_next;
            colour_reg    <= colour_next;
            p1_valid_reg  <= p1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p1_load)
        begin
            // floor of the accumulator: arithmetic drop of the fraction
            p1_x_reg      <= x_acc_next[ACC_W-1:FRAC_BITS];
            p1_y_reg      <= y_acc_next[ACC_W-1:FRAC_BITS];
            p1_last_reg   <= (left_next == '0);
            p1_colour_reg <= colour_next;
        end
        if (out_load)
        begin
            out_x_reg      <= p1_x_reg[COORD_BITS-1:0];
            out_y_reg      <= p1_y_reg[COORD_BITS-1:0];
            out_addr_reg   <= addr_calc;
            out_colour_reg <= p1_colour_reg;
            out_last_reg   <= p1_last_reg;
        end
    end

    assign pixel.valid         = out_valid_reg;
    assign pixel.pixel_x       = out_x_reg;
    assign pixel.pixel_y       = out_y_reg;
    assign pixel.pixel_address = out_addr_reg;
    assign pixel.pixel_colour  = out_colour_reg;
    assign pixel.last_pixel    = out_last_reg;

    // start command stays at the queue head for the whole division
    a_div_holds_head: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (head_valid && head_cmd.is_start))
        else $error("start command left queue head during division");

    a_div_launch: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> div_busy)
        else $error("divider did not start");

    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DIV) && !div_busy && !p1_free) |=> (state_reg == ST_DIV))
        else $error("line setup finished while pixel stage was full");

    a_no_line_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (adv_go && (left_reg == '0) && !p1_valid_reg) |=> !p1_valid_reg)
        else $error("pixel produced by advance with no active line");

endmodule

// File: hdl/fixed_point_line_stepper.sv
// Top level of the fixed-point DDA line stepper: command queue, divider, stepper.
// Throughput: one advance per cycle while the pixel output is not stalled; a start
//   holds the back end for the COORD_BITS+FRAC_BITS+1 step restoring divide of the
//   minor step (23 divider steps at defaults).
// Reset: no line active, accumulators and steps zero, row_width = 320.
module fixed_point_line_stepper
    import fls_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    fls_item_if.sink         item,
    fls_pixel_if.source      pixel,
    input  logic             cfg_wr_en,
    input  logic [ROW_W-1:0] cfg_wr_data
);

    // dividend is |minor delta|+1 scaled by the fraction, divisor is line length
    localparam int NUM_W = COORD_BITS + 1 + FRAC_BITS;
    localparam int DEN_W = COORD_BITS + 1;

    // frame buffer row width register; the user must write it only while idle, the block does not enforce this
    logic [ROW_W-1:0] row_width_reg;

    // queue head seen by the back end
    logic                  head_valid;
    fls_cmd_t              head_cmd;
    logic [COORD_BITS-1:0] head_x0;
    logic [COORD_BITS-1:0] head_y0;
    logic [COORD_BITS:0]   head_len;
    logic [COORD_BITS:0]   head_adj;
    logic [COLOUR_W-1:0]   head_colour;
    logic                  pop;

    // divider handshake
    logic             div_start;
    logic             div_busy;
    logic [NUM_W-1:0] div_quo;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= ROW_W'(ROW_WIDTH_RESET);
        end
        else if (cfg_wr_en)
        begin
            row_width_reg <= cfg_wr_data;
        end
    end

    // front: accept transactions while the queue has room, classify starts, queue
    fls_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .head_valid  (head_valid),
        .head_cmd    (head_cmd),
        .head_x0     (head_x0),
        .head_y0     (head_y0),
        .head_len    (head_len),
        .head_adj    (head_adj),
        .head_colour (head_colour),
        .pop         (pop)
    );

    // minor step magnitude = (adj << FRAC_BITS) / len, at most 2^FRAC_BITS
    fls_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   ({head_adj, {FRAC_BITS{1'b0}}}),
        .den   (head_len),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    // back: step accumulators, form address, register the pixel
    fls_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_cmd    (head_cmd),
        .head_x0     (head_x0),
        .head_y0     (head_y0),
        .head_len    (head_len),
        .head_colour (head_colour),
        .pop         (pop),
        .div_start   (div_start),
        .div_busy    (div_busy),
        .div_quo     (div_quo[FRAC_BITS:0]),
        .row_width   (row_width_reg),
        .pixel       (pixel)
    );

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the fixed-point DDA line stepper.
`timescale 1ns / 100ps

module tb_top;
    import fls_pkg::*;

    localparam int CB            = COORD_BITS_DEF;
    localparam int FB            = FRAC_BITS_DEF;
    localparam int COORD_MAX     = (1 << CB) - 1;
    localparam int ONE_PIXEL     = 1 << FB;
    // generous drain allowance that covers the start latency
    localparam int SETTLE        = 2 * (CB + FB + 5);
    localparam int CYCLE_LIMIT   = 500000;
    localparam int STALL_CYCLES  = 300;
    localparam int RANDOM_PIXELS = 1000;
    localparam int CFG_INTERVAL  = 250;
    localparam int MAX_REPORTS   = 10;

    // one command transaction as it goes on the wire
    typedef struct packed {
        logic                kind;
        logic [CB-1:0]       start_x;
        logic [CB-1:0]       start_y;
        logic [CB-1:0]       end_x;
        logic [CB-1:0]       end_y;
        logic [COLOUR_W-1:0] colour;
    } line_item_t;

    // one pixel transaction
    typedef struct packed {
        logic [CB-1:0]       pixel_x;
        logic [CB-1:0]       pixel_y;
        logic [ADDR_W-1:0]   pixel_address;
        logic [COLOUR_W-1:0] pixel_colour;
        logic                last_pixel;
    } pixel_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [ROW_W-1:0] cfg_wr_data;

    fls_item_if  #(.COORD_BITS(CB)) item_ch ();
    fls_pixel_if #(.COORD_BITS(CB)) pixel_ch ();

    fixed_point_line_stepper #(
        .COORD_BITS (CB),
        .FRAC_BITS  (FB)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item_ch),
        .pixel       (pixel_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // ------------------------------------------------------------------
    // Rasterizer shadow state. Accumulators and steps are signed fixed
    // point with FB fraction bits, held at the block's 24-bit width.
    // ------------------------------------------------------------------
    logic signed [ADDR_W-1:0] x_acc;
    logic signed [ADDR_W-1:0] y_acc;
    logic signed [ADDR_W-1:0] x_inc;
    logic signed [ADDR_W-1:0] y_inc;
    logic [ROW_W-1:0]         pixels_to_go;   // zero: no line in progress
    logic [ROW_W-1:0]         row_width;
    logic [COLOUR_W-1:0]      latched_colour;

    pixel_t pending_pixels[$];   // pixels predicted but not yet seen
    int     mismatches;
    int     pixels_sent;         // transactions that produced a pixel
    bit     quiet;               // suppresses random idling on both sides
    bit     stall_toggle;        // flip to start a long receiver hold-off

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Minor-axis step: (delta +/- 1) scaled up, divided by the length.
    // Signed int division truncates toward zero, as the block does.
    function automatic int minor_inc(input int from, input int to, input int len);
        int adj;
        adj = (from <= to) ? to - from + 1 : to - from - 1;
        return (adj * ONE_PIXEL) / len;
    endfunction

    // Pixel at the current accumulators. The coordinate is the floor of
    // the accumulator, so an overshoot below zero wraps to the top of the
    // coordinate range; the address is taken from the signed values.
    function automatic pixel_t pixel_at(input bit last);
        int     xs;
        int     ys;
        int     addr;
        pixel_t p;
        xs = x_acc >>> FB;
        ys = y_acc >>> FB;
        addr = ys * int'(row_width) + xs;
        p.pixel_x       = xs[CB-1:0];
        p.pixel_y       = ys[CB-1:0];
        p.pixel_address = addr[ADDR_W-1:0];
        p.pixel_colour  = latched_colour;
        p.last_pixel    = last;
        return p;
    endfunction

    // Applies one accepted command; returns 1 with the pixel it causes.
    function automatic bit rasterize_step(input line_item_t it, output pixel_t p);
        int x0;
        int y0;
        int x1;
        int y1;
        int adx;
        int ady;
        int len;
        p = '0;
        if (it.kind == KIND_START)
        begin
            x0 = int'(it.start_x);
            y0 = int'(it.start_y);
            x1 = int'(it.end_x);
            y1 = int'(it.end_y);
            adx = (x1 >= x0) ? x1 - x0 : x0 - x1;
            ady = (y1 >= y0) ? y1 - y0 : y0 - y1;
            // x is major on a tie
            if (adx >= ady)
            begin
                len   = adx + 1;
                x_inc = ADDR_W'((x0 > x1) ? -ONE_PIXEL : ONE_PIXEL);
                y_inc = ADDR_W'(minor_inc(y0, y1, len));
            end
            else
            begin
                len   = ady + 1;
                y_inc = ADDR_W'((y0 > y1) ? -ONE_PIXEL : ONE_PIXEL);
                x_inc = ADDR_W'(minor_inc(x0, x1, len));
            end
            x_acc          = ADDR_W'(x0 * ONE_PIXEL);
            y_acc          = ADDR_W'(y0 * ONE_PIXEL);
            latched_colour = it.colour;
            pixels_to_go   = ROW_W'(len - 1);
            p = pixel_at(pixels_to_go == 0);
            return 1'b1;
        end
        // advance past the end of a line, or with none started: dropped
        if (pixels_to_go == 0)
            return 1'b0;
        x_acc        = x_acc + x_inc;
        y_acc        = y_acc + y_inc;
        pixels_to_go = pixels_to_go - 1'b1;
        p = pixel_at(pixels_to_go == 0);
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    function automatic line_item_t line_start(input int x0, input int y0,
                                              input int x1, input int y1,
                                              input int colour);
        line_item_t it;
        it.kind    = KIND_START;
        it.start_x = CB'(x0);
        it.start_y = CB'(y0);
        it.end_x   = CB'(x1);
        it.end_y   = CB'(y1);
        it.colour  = COLOUR_W'(colour);
        return it;
    endfunction

    // Random coordinate within span of p, clamped to the raster.
    function automatic int near(input int p, input int span);
        int v;
        v = p + int'($urandom_range(2 * span)) - span;
        if (v < 0)
            v = 0;
        if (v > COORD_MAX)
            v = COORD_MAX;
        return v;
    endfunction

    // Offers one transaction and predicts at the edge it is taken.
    // Valid is left high afterwards so back-to-back transactions never
    // lower and raise it in the same time step.
    task automatic send_item(input line_item_t it);
        pixel_t p;
        if (!quiet)
            while ($urandom_range(99) < 10)
            begin
                item_ch.valid <= 1'b0;
                @(posedge clk);
            end
        item_ch.valid   <= 1'b1;
        item_ch.kind    <= it.kind;
        item_ch.start_x <= it.start_x;
        item_ch.start_y <= it.start_y;
        item_ch.end_x   <= it.end_x;
        item_ch.end_y   <= it.end_y;
        item_ch.colour  <= it.colour;
        do
            @(posedge clk);
        while (item_ch.ready !== 1'b1);
        if (rasterize_step(it, p))
        begin
            pending_pixels.push_back(p);
            pixels_sent++;
        end
    endtask

    // n advance transactions; the endpoint fields are don't-care, so
    // they carry noise.
    task automatic advance(input int n);
        line_item_t it;
        repeat (n)
        begin
            it.kind    = KIND_ADVANCE;
            it.start_x = CB'($urandom_range(COORD_MAX));
            it.start_y = CB'($urandom_range(COORD_MAX));
            it.end_x   = CB'($urandom_range(COORD_MAX));
            it.end_y   = CB'($urandom_range(COORD_MAX));
            it.colour  = COLOUR_W'($urandom_range(255));
            send_item(it);
        end
    endtask

    // Drop valid, wait out every predicted pixel, then a further settling wait
    // since dropped advances leave nothing to wait on.
    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_row_width(input int value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= ROW_W'(value);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        row_width = ROW_W'(value);
    endtask

    // ------------------------------------------------------------------
    // Receiver side: random ready, plus a long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        int stall_left;
        bit seen_toggle;
        stall_left  = 0;
        seen_toggle = 1'b0;
        pixel_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_toggle != seen_toggle)
            begin
                seen_toggle = stall_toggle;
                stall_left  = STALL_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                pixel_ch.ready <= 1'b0;
            end
            else
                pixel_ch.ready <= quiet || ($urandom_range(99) >= 10);
        end
    end

    function automatic void note_error(input string msg);
        if (mismatches < MAX_REPORTS)
            $display("ERROR @%0t: %s", $time, msg);
        mismatches++;
    endfunction

    // Pixel checker: every accepted pixel against the oldest prediction.
    initial
    begin
        pixel_t got;
        pixel_t want;
        string  msg;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && pixel_ch.valid === 1'b1 && pixel_ch.ready === 1'b1)
            begin
                got.pixel_x       = pixel_ch.pixel_x;
                got.pixel_y       = pixel_ch.pixel_y;
                got.pixel_address = pixel_ch.pixel_address;
                got.pixel_colour  = pixel_ch.pixel_colour;
                got.last_pixel    = pixel_ch.last_pixel;
                if (pending_pixels.size() == 0)
                    note_error($sformatf("unexpected pixel x=%0d y=%0d addr=%0h",
                                         got.pixel_x, got.pixel_y, got.pixel_address));
                else
                begin
                    want = pending_pixels.pop_front();
                    if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
                        got.pixel_address !== want.pixel_address ||
                        got.pixel_colour !== want.pixel_colour ||
                        got.last_pixel !== want.last_pixel)
                    begin
                        msg = {$sformatf("pixel exp x=%0d y=%0d addr=%0h col=%0h last=%0b",
                                         want.pixel_x, want.pixel_y, want.pixel_address,
                                         want.pixel_colour, want.last_pixel),
                               $sformatf(", got x=%0d y=%0d addr=%0h col=%0h last=%0b",
                                         got.pixel_x, got.pixel_y, got.pixel_address,
                                         got.pixel_colour, got.last_pixel)};
                        note_error(msg);
                    end
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("ERROR: timeout after %0d cycles, %0d pixels outstanding",
                 cycle_count, pending_pixels.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Line shapes and edge cases at the reset row width.
    task automatic test_shapes();
        // advance straight out of reset: nothing active, no pixel
        advance(1);
        // single-pixel line: last on the start pixel, next advance dropped
        send_item(line_start(5, 7, 5, 7, 8'hFF));
        advance(1);
        // horizontal along the top row, colour zero
        send_item(line_start(0, 0, 3, 0, 8'h00));
        advance(3);
        // y falling by one over an x run: minor axis dips below zero;
        // third advance is past the end
        send_item(line_start(0, 1, 2, 0, 8'h5A));
        advance(3);
        // 45 degrees, tie resolves to x major
        send_item(line_start(10, 10, 13, 13, 8'hA5));
        advance(3);
        // full-span diagonal from the far corner, cut short by a new start
        send_item(line_start(COORD_MAX, 0, 0, COORD_MAX, 8'h3C));
        advance(2);
        // y major, both coordinates falling
        send_item(line_start(COORD_MAX, COORD_MAX, COORD_MAX - 2, COORD_MAX - 6, 8'hC3));
        advance(2);
    endtask

    // Row width extremes, including out-of-range values used as written.
    task automatic test_row_widths();
        int widths[6];
        int x0;
        int y0;
        widths = '{1, 4096, 0, 8191, 320, 0};
        widths[5] = $urandom_range(1, 4096);
        foreach (widths[i])
        begin
            write_row_width(widths[i]);
            // near the far corner so the address product wraps
            x0 = $urandom_range(COORD_MAX - 8, COORD_MAX);
            y0 = $urandom_range(COORD_MAX - 8, COORD_MAX);
            send_item(line_start(x0, y0, near(x0, 4), near(y0, 4), $urandom_range(255)));
            advance(5);
        end
    endtask

    // Receiver holds off while the sender keeps pushing one line, so the
    // command queue fills and the input stalls.
    task automatic test_backpressure();
        stall_toggle <= ~stall_toggle;
        send_item(line_start(100, 200, 147, 180, 8'h77));
        advance(47);
        wait_idle();
    endtask

    // One long line with no idling on either side. y drops by three over
    // ~300 pixels, so the truncated step overshoots below zero at the end.
    task automatic test_long_line();
        quiet <= 1'b1;
        send_item(line_start(COORD_MAX, 3, COORD_MAX - 295, 0, $urandom_range(255)));
        advance(296);
        wait_idle();
        quiet <= 1'b0;
    endtask

    // Random lines, mostly driven to their end (sometimes past it), some
    // cut short, plus stray advances. Row width changes between batches.
    task automatic test_random_lines();
        int target;
        int next_cfg;
        int span;
        int x0;
        int y0;
        int x1;
        int y1;
        int len;
        target   = pixels_sent + RANDOM_PIXELS;
        next_cfg = pixels_sent + CFG_INTERVAL;
        while (pixels_sent < target)
        begin
            if (pixels_sent >= next_cfg)
            begin
                write_row_width($urandom_range(1, 4096));
                next_cfg += CFG_INTERVAL;
            end
            if ($urandom_range(9) == 0)
                advance($urandom_range(1, 3));
            else
            begin
                span = ($urandom_range(7) == 0) ? 120 : 12;
                x0 = $urandom_range(COORD_MAX);
                y0 = $urandom_range(COORD_MAX);
                x1 = near(x0, span);
                y1 = near(y0, span);
                len = (x1 > x0) ? x1 - x0 : x0 - x1;
                if (((y1 > y0) ? y1 - y0 : y0 - y1) > len)
                    len = (y1 > y0) ? y1 - y0 : y0 - y1;
                len = len + 1;
                send_item(line_start(x0, y0, x1, y1, $urandom_range(255)));
                if ($urandom_range(7) == 0)
                    advance($urandom_range(len - 1));
                else
                    advance(len - 1 + $urandom_range(2));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n           <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_wr_data     <= '0;
        item_ch.valid   <= 1'b0;
        item_ch.kind    <= KIND_START;
        item_ch.start_x <= '0;
        item_ch.start_y <= '0;
        item_ch.end_x   <= '0;
        item_ch.end_y   <= '0;
        item_ch.colour  <= '0;
        quiet           <= 1'b0;
        stall_toggle    <= 1'b0;

        // shadow state matches the block after reset
        x_acc          = '0;
        y_acc          = '0;
        x_inc          = '0;
        y_inc          = '0;
        pixels_to_go   = '0;
        row_width      = ROW_W'(ROW_WIDTH_RESET);
        latched_colour = '0;
        mismatches     = 0;
        pixels_sent    = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_shapes();
        test_row_widths();
        test_backpressure();
        test_long_line();
        test_random_lines();
        wait_idle();

        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: sim.f
hdl/fls_pkg.sv
hdl/fls_ifs.sv
hdl/fls_front.sv
hdl/fls_div.sv
hdl/fls_back.sv
hdl/fixed_point_line_stepper.sv
dv/tb_top.sv
